[design/vdi_pkg.sv]
// ----------------------------------------------------------------------------
// vdi_pkg
// shared sizes, result word type and sequencer states for the value
// dictionary interning core
// ----------------------------------------------------------------------------
package vdi_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int VALUE_BITS    = 32;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = IDX_BITS + 1;
   localparam int KEY_BITS      = 9;
   localparam int OCC_BITS      = 32;

   typedef logic [VALUE_BITS-1:0] val_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [OCC_BITS-1:0]   occ_type;

   // one result word as it leaves the core
   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic                       is_new;
      occ_type                    occurrences;
      logic [KEY_BITS-1:0]        distinct_total;
      occ_type                    null_total;
      logic                       table_full;
   } res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CNT_RD,
      ST_CNT_UPD,
      ST_INSERT,
      ST_FINISH
   } st_type;

   localparam logic signed [KEY_BITS-1:0] KEY_NONE = '1;

   function automatic occ_type sat_inc(input occ_type c);
      sat_inc = (c == '1) ? c : c + occ_type'(1);
   endfunction

endpackage

[design/value_dictionary_interning_core.sv]
// ----------------------------------------------------------------------------
// value_dictionary_interning_core
// dictionary encoder for integers with per-value occurrence counts
// ----------------------------------------------------------------------------
// Each request word carries a value or a null marker. A null bumps the
// saturating null counter and answers key -1. A value is looked up among the
// distinct values stored so far by a linear scan through the key ram with a
// single comparator, one entry per cycle in insertion order. A hit bumps that
// entry's saturating count and answers its key; a miss stores the value under
// the next dense key with count 1 and flags is_new, or, once all 256 entries
// are taken, answers key -1 with table_full set. Items are handled one at a
// time and req_stall stays high while one is in flight. A null item goes
// from idle straight to finish; a present value is scanned, then a hit
// passes through count read and count update and a miss through insert
// (insert directly when the table is empty) before finish. The scan length
// is set by the one key ram read port feeding the comparator. The sequencer
// returns to idle before the next word is taken. The result sits in an output
// register, so a stalled rsp side holds back only the next item's finish.
// No clearing pass is needed after reset: only entries below the distinct
// count are ever read.
// ----------------------------------------------------------------------------
module value_dictionary_interning_core
   import vdi_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_value_present,
   input  logic signed [31:0]         req_value,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [KEY_BITS-1:0] rsp_key,
   output logic                       rsp_is_new,
   output logic [31:0]                rsp_occurrences,
   output logic [KEY_BITS-1:0]        rsp_distinct_total,
   output logic [31:0]                rsp_null_total,
   output logic                       rsp_table_full
);

   logic    rsp_valid_ff;
   res_type rsp_ff;
   logic    out_free;
   logic    res_load;
   res_type res;

   // output register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer, key ram, count ram and the shared comparator
   vdi_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_value_present (req_value_present),
      .req_value         (req_value),
      .req_stall         (req_stall),
      .out_free          (out_free),
      .res_load          (res_load),
      .res               (res)
   );

   // response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, held while stalled
   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key            = rsp_ff.key;
   assign rsp_is_new         = rsp_ff.is_new;
   assign rsp_occurrences    = rsp_ff.occurrences;
   assign rsp_distinct_total = rsp_ff.distinct_total;
   assign rsp_null_total     = rsp_ff.null_total;
   assign rsp_table_full     = rsp_ff.table_full;

endmodule

[design/vdi_ram.sv]
// ----------------------------------------------------------------------------
// vdi_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vdi_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/vdi_ctrl.sv]
// ----------------------------------------------------------------------------
// vdi_ctrl
// sequencer: linear key scan with one comparator, count update, insert
// ----------------------------------------------------------------------------
module vdi_ctrl
   import vdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_value_present,
   input  logic signed [31:0] req_value,
   output logic        req_stall,
   input  logic        out_free,
   output logic        res_load,
   output res_type     res
);

   st_type    state_ff, state_in;
   val_type   val_ff;
   cnt_type   issue_ff;
   logic      cmp_vld_ff;
   idx_type   cmp_idx_ff;
   idx_type   hit_idx_ff;
   cnt_type   distinct_ff;
   occ_type   null_ff;
   res_type   res_ff;

   logic      key_we, cnt_we;
   idx_type   key_waddr, cnt_waddr;
   occ_type   cnt_wdata;
   val_type   key_rdata;
   occ_type   cnt_rdata;
   logic      match, last_cmp, full, issue_more;

   vdi_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(VALUE_BITS)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (val_ff),
      .raddr (issue_ff[IDX_BITS-1:0]),
      .rdata (key_rdata)
   );

   vdi_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(OCC_BITS)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (hit_idx_ff),
      .rdata (cnt_rdata)
   );

   assign match      = cmp_vld_ff && (key_rdata == val_ff);
   assign last_cmp   = cmp_vld_ff && ((cnt_type'(cmp_idx_ff) + cnt_type'(1)) == distinct_ff);
   assign full       = (distinct_ff == cnt_type'(TABLE_ENTRIES));
   assign issue_more = (issue_ff < distinct_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_value_present) begin
                  state_in = ST_FINISH;
               end else if (distinct_ff == '0) begin
                  state_in = ST_INSERT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = ST_CNT_RD;
            end else if (last_cmp) begin
               state_in = ST_INSERT;
            end
         end
         ST_CNT_RD:  state_in = ST_CNT_UPD;
         ST_CNT_UPD: state_in = ST_FINISH;
         ST_INSERT:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b1;
      key_we    = 1'b0;
      cnt_we    = 1'b0;
      key_waddr = distinct_ff[IDX_BITS-1:0];
      cnt_waddr = hit_idx_ff;
      cnt_wdata = sat_inc(cnt_rdata);
      res_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_SCAN:    ;
         ST_CNT_RD:  ;
         ST_CNT_UPD: cnt_we = 1'b1;
         ST_INSERT: begin
            key_we    = !full;
            cnt_we    = !full;
            cnt_waddr = distinct_ff[IDX_BITS-1:0];
            cnt_wdata = occ_type'(1);
         end
         ST_FINISH:  res_load = out_free;
         default:    ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         distinct_ff <= '0;
         null_ff     <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= (state_ff == ST_SCAN) && issue_more;
         if (state_ff == ST_IDLE && req_valid && !req_value_present) begin
            null_ff <= sat_inc(null_ff);
         end
         if (state_ff == ST_INSERT && !full) begin
            distinct_ff <= distinct_ff + cnt_type'(1);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= issue_ff[IDX_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            val_ff   <= val_type'(req_value);
            issue_ff <= '0;
            res_ff.key            <= KEY_NONE;
            res_ff.is_new         <= 1'b0;
            res_ff.occurrences    <= '0;
            res_ff.distinct_total <= KEY_BITS'(distinct_ff);
            res_ff.null_total     <= sat_inc(null_ff);
            res_ff.table_full     <= 1'b0;
         end
         ST_SCAN: begin
            if (issue_more) begin
               issue_ff <= issue_ff + cnt_type'(1);
            end
            if (match) begin
               hit_idx_ff <= cmp_idx_ff;
            end
         end
         ST_CNT_UPD: begin
            res_ff.key            <= KEY_BITS'(hit_idx_ff);
            res_ff.is_new         <= 1'b0;
            res_ff.occurrences    <= sat_inc(cnt_rdata);
            res_ff.distinct_total <= KEY_BITS'(distinct_ff);
            res_ff.null_total     <= null_ff;
            res_ff.table_full     <= 1'b0;
         end
         ST_INSERT: begin
            res_ff.null_total <= null_ff;
            if (full) begin
               res_ff.key            <= KEY_NONE;
               res_ff.is_new         <= 1'b0;
               res_ff.occurrences    <= '0;
               res_ff.distinct_total <= KEY_BITS'(distinct_ff);
               res_ff.table_full     <= 1'b1;
            end else begin
               res_ff.key            <= KEY_BITS'(distinct_ff);
               res_ff.is_new         <= 1'b1;
               res_ff.occurrences    <= occ_type'(1);
               res_ff.distinct_total <= KEY_BITS'(distinct_ff + cnt_type'(1));
               res_ff.table_full     <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   assign res = res_ff;

endmodule

[tb/value_dictionary_interning_checker.sv]
// ----------------------------------------------------------------------------
// value_dictionary_interning_checker
// watches both channels of the interning core, predicts every result word
// and compares it field by field with what the core returns
// ----------------------------------------------------------------------------
module value_dictionary_interning_checker
   import vdi_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_value_present,
   input  logic signed [31:0]         req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [KEY_BITS-1:0] rsp_key,
   input  logic                       rsp_is_new,
   input  logic [31:0]                rsp_occurrences,
   input  logic [KEY_BITS-1:0]        rsp_distinct_total,
   input  logic [31:0]                rsp_null_total,
   input  logic                       rsp_table_full,
   output int unsigned                fail_count,
   output int unsigned                pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   val_type     stored_value [TABLE_ENTRIES];
   occ_type     stored_count [TABLE_ENTRIES];
   int          distinct_seen = 0;
   occ_type     null_seen     = '0;
   res_type     expected_q [$];
   res_type     due_word;
   res_type     next_word;
   int unsigned mismatches    = 0;

   // dictionary lookup / insert, updates the shadow tables
   function automatic res_type intern_word(input logic present, input val_type val);
      res_type r;
      int      hit;
      r     = '0;
      r.key = KEY_NONE;
      hit   = distinct_seen;
      if (!present) begin
         if (null_seen != '1) null_seen = null_seen + 1'b1;
      end else begin
         for (int i = 0; i < distinct_seen; i++)
            if (hit == distinct_seen && stored_value[i] == val) hit = i;
         if (hit < distinct_seen) begin
            if (stored_count[hit] != '1) stored_count[hit] = stored_count[hit] + 1'b1;
            r.key         = hit[KEY_BITS-1:0];
            r.occurrences = stored_count[hit];
         end else if (distinct_seen < TABLE_ENTRIES) begin
            stored_value[distinct_seen] = val;
            stored_count[distinct_seen] = 1;
            r.key         = distinct_seen[KEY_BITS-1:0];
            r.is_new      = 1'b1;
            r.occurrences = 1;
            distinct_seen++;
         end else begin
            r.table_full = 1'b1;
         end
      end
      r.distinct_total = distinct_seen[KEY_BITS-1:0];
      r.null_total     = null_seen;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t rsp %s: expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         distinct_seen = 0;
         null_seen     = '0;
         expected_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            next_word  = intern_word(req_value_present, req_value);
            expected_q = {expected_q, next_word};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t rsp word: expected none, got key %0d", $time, rsp_key);
            end else begin
               due_word = expected_q.pop_front();
               check_field("key", due_word.key, rsp_key);
               check_field("is_new", due_word.is_new, rsp_is_new);
               check_field("occurrences", due_word.occurrences, rsp_occurrences);
               check_field("distinct_total", due_word.distinct_total, rsp_distinct_total);
               check_field("null_total", due_word.null_total, rsp_null_total);
               check_field("table_full", due_word.table_full, rsp_table_full);
            end
         end
      end
      fail_count    <= mismatches;
      pending_words <= expected_q.size();
   end

endmodule

[tb/value_dictionary_interning_core_test.sv]
// ----------------------------------------------------------------------------
// value_dictionary_interning_core_test
// drives null and value words into the interning core under three idling
// mixes, fills the dictionary past its last entry, and takes the verdict
// from the checker that sits beside the core
// ----------------------------------------------------------------------------
module value_dictionary_interning_core_test
   import vdi_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // run length limit, several times the slowest correct run of ~1200 words
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          WORDS_PER_PHASE = 384;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // every core input known from time zero
   logic                       req_valid         = 1'b0;
   logic                       req_value_present = 1'b0;
   logic signed [31:0]         req_value         = '0;
   logic                       rsp_stall         = 1'b0;

   logic                       req_stall;
   logic                       rsp_valid;
   logic signed [KEY_BITS-1:0] rsp_key;
   logic                       rsp_is_new;
   logic [31:0]                rsp_occurrences;
   logic [KEY_BITS-1:0]        rsp_distinct_total;
   logic [31:0]                rsp_null_total;
   logic                       rsp_table_full;

   int unsigned fail_count;
   int unsigned pending_words;
   int unsigned cycle_count = 0;

   // idling odds in percent; the stall odds change only by nonblocking write
   int unsigned send_gap_pct  = 10;
   int unsigned rsp_stall_pct = 73;

   // every present value sent so far, source of dictionary hits
   logic [31:0] sent_values [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   value_dictionary_interning_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value_present  (req_value_present),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key            (rsp_key),
      .rsp_is_new         (rsp_is_new),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_distinct_total (rsp_distinct_total),
      .rsp_null_total     (rsp_null_total),
      .rsp_table_full     (rsp_table_full)
   );

   value_dictionary_interning_checker u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value_present  (req_value_present),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key            (rsp_key),
      .rsp_is_new         (rsp_is_new),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_distinct_total (rsp_distinct_total),
      .rsp_null_total     (rsp_null_total),
      .rsp_table_full     (rsp_table_full),
      .fail_count         (fail_count),
      .pending_words      (pending_words)
   );

   // receiver side: random back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one request word: optional idle gap, then hold until the core takes it.
   // valid is lowered only on gap cycles, so it never gets two writes per step
   task automatic send_word(input logic present, input logic [31:0] val);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_value_present <= present;
      req_value         <= val;
      if (present) sent_values = {sent_values, val};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender off until every outstanding result word is back;
   // a wait on the clock first lets the checker count the word just accepted
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // random mix: nulls, repeats of earlier values (hits, and after the table
   // fills also repeats of values that were turned away), and fresh values
   // that keep growing the dictionary until it overflows
   task automatic send_random_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15)
         send_word(1'b0, $urandom);
      else if (pick < 57 && sent_values.size() != 0)
         send_word(1'b1, sent_values[$urandom_range(sent_values.size() - 1)]);
      else
         send_word(1'b1, $urandom);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed opening: nulls, extremes of the value range, first hits
      send_word(1'b0, 32'h0000_0000);
      send_word(1'b1, 32'h0000_0000);   // key 0, new
      send_word(1'b1, 32'h0000_0000);   // hit, count 2
      send_word(1'b1, 32'hFFFF_FFFF);   // -1 as a value, not a null
      send_word(1'b1, 32'h8000_0000);   // most negative
      send_word(1'b1, 32'h7FFF_FFFF);   // most positive
      send_word(1'b0, 32'hFFFF_FFFF);   // null, payload ignored
      send_word(1'b1, 32'h0000_0001);
      send_word(1'b1, 32'hFFFF_FFFF);
      send_word(1'b1, 32'h8000_0000);
      send_word(1'b1, 32'h7FFF_FFFF);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b1, 32'h5555_5555);
      send_word(1'b1, 32'hAAAA_AAAA);
      send_word(1'b1, 32'hAAAA_AAAA);
      send_word(1'b1, 32'h0000_0000);   // first entry hit again, count 3
      send_word(1'b1, 32'h0000_0001);
      send_word(1'b0, 32'h0000_0000);
      drain_results();

      // three idling mixes; each ends with a full pause until drained.
      // count saturation at 2^32-1 is out of reach in a run this short
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct  = 10;
               rsp_stall_pct <= 73;
            end
            1: begin
               send_gap_pct  = 73;
               rsp_stall_pct <= 10;
            end
            default: begin
               send_gap_pct  = 0;
               rsp_stall_pct <= 0;
            end
         endcase
         repeat (WORDS_PER_PHASE) send_random_word();
         drain_results();
      end

      // room for any stray word after the last expected one
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
